>>> hdl/isc_pkg.sv
// shared types and codes for the interval statistics counter bank
package isc_pkg;

   typedef logic [31:0] word_type;
   typedef logic [15:0] mask_type;
   typedef logic [1:0]  kind_type;
   typedef logic [3:0]  index_type;

   // item kinds
   localparam kind_type KIND_START  = 2'd0;
   localparam kind_type KIND_STOP   = 2'd1;
   localparam kind_type KIND_PERIOD = 2'd2;
   localparam kind_type KIND_READ   = 2'd3;

   // counters that own an enable bit
   localparam int MASK_BITS = 16;

   // shared unit modes
   typedef logic [1:0] alu_mode_type;
   localparam alu_mode_type ALU_SUB    = 2'd0;
   localparam alu_mode_type ALU_SATADD = 2'd1;
   localparam alu_mode_type ALU_CMP    = 2'd2;

   typedef struct packed {
      alu_mode_type mode;
      word_type     a;
      word_type     b;
   } alu_req_type;

   typedef struct packed {
      word_type result;
      logic     a_gt_b;
   } alu_out_type;

   // one counter entry as it sits in the store
   typedef struct packed {
      logic     running;
      word_type start_tick;
      word_type call_total;
      word_type tick_total;
      word_type max_interval;
      word_type calls_in_period;
      word_type ticks_in_period;
      word_type max_period_calls;
      word_type max_period_ticks;
   } entry_type;

   // one result beat
   typedef struct packed {
      word_type total_calls;
      word_type total_ticks;
      word_type longest_interval;
      word_type period_calls;
      word_type period_ticks;
      word_type peak_period_calls;
      word_type peak_period_ticks;
      logic     is_running;
   } result_type;

endpackage

>>> hdl/isc_channels.sv
// request and response channel interfaces
interface isc_req_if;
   import isc_pkg::*;

   logic      valid;
   logic      ready;
   kind_type  kind;
   index_type counter_index;
   word_type  now_ticks;

   modport source (output valid, output kind, output counter_index, output now_ticks,
                   input ready);
   modport sink (input valid, input kind, input counter_index, input now_ticks,
                 output ready);
endinterface

interface isc_rsp_if;
   import isc_pkg::*;

   logic     valid;
   logic     ready;
   word_type total_calls;
   word_type total_ticks;
   word_type longest_interval;
   word_type period_calls;
   word_type period_ticks;
   word_type peak_period_calls;
   word_type peak_period_ticks;
   logic     is_running;

   modport source (output valid, output total_calls, output total_ticks,
                   output longest_interval, output period_calls, output period_ticks,
                   output peak_period_calls, output peak_period_ticks, output is_running,
                   input ready);
   modport sink (input valid, input total_calls, input total_ticks,
                 input longest_interval, input period_calls, input period_ticks,
                 input peak_period_calls, input peak_period_ticks, input is_running,
                 output ready);
endinterface

>>> hdl/interval_statistics_counter_bank.sv
// top level: sequencer, shared arithmetic unit, counter store and result register
//
// A bank of NUM_COUNTERS interval counters kept in one single-port-per-side memory
// and updated by one shared 32-bit adder/comparator. The request channel accepts a
// beat only while the sequencer is idle. A read item reads the addressed counter; a start
// reads it and, if it is not running, writes it back; a stop on a running counter takes
// one memory read, six passes through the shared unit and one write. A period
// boundary walks counters 0 up to min(NUM_COUNTERS,16)-1: a disabled counter is
// skipped, an enabled one is read, compared twice and written, and then the addressed
// counter is read. The shared unit does one add or compare per cycle, and the store
// has one read and one write port. The result register holds a finished beat until
// it is taken; a new request is taken meanwhile, and its result waits until the
// register frees. Counter statistics clear at reset through per-entry valid bits, with
// no clearing pass. The user must write the enable mask through csr_wr_en/csr_wr_data
// only while the block is idle; the block itself does not enforce this.
module interval_statistics_counter_bank #(
   parameter int NUM_COUNTERS = 16
) (
   input  logic               clock,
   input  logic               reset,
   isc_req_if.sink            req_chan,
   isc_rsp_if.source          rsp_chan,
   input  logic               csr_wr_en,
   input  isc_pkg::mask_type  csr_wr_data
);
   import isc_pkg::*;

   localparam int ADDR_W = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
   localparam int WIDE_W = ADDR_W + 4;
   localparam int ROLL_N = (NUM_COUNTERS < MASK_BITS) ? NUM_COUNTERS : MASK_BITS;
   localparam logic [ADDR_W-1:0] ROLL_LAST = ADDR_W'(ROLL_N - 1);
   localparam logic [8:0] NUM_LIMIT = 9'(NUM_COUNTERS);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_LOAD  = 3'd3;
   localparam logic [2:0] ST_EXEC  = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   // shared unit steps
   localparam logic [2:0] OP_ELAPSED = 3'd0;
   localparam logic [2:0] OP_CALLS   = 3'd1;
   localparam logic [2:0] OP_TICKS   = 3'd2;
   localparam logic [2:0] OP_PCALLS  = 3'd3;
   localparam logic [2:0] OP_PTICKS  = 3'd4;
   localparam logic [2:0] OP_MAXINT  = 3'd5;
   localparam logic [2:0] OP_PKCALLS = 3'd6;
   localparam logic [2:0] OP_PKTICKS = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic              roll_ff, roll_in;
   logic [ADDR_W-1:0] walk_ff, walk_in;
   kind_type          kind_ff, kind_in;
   logic [ADDR_W-1:0] idx_addr_ff, idx_addr_in;
   logic              idx_ok_ff, idx_ok_in;
   word_type          now_ff, now_in;
   word_type          elapsed_ff, elapsed_in;
   entry_type         work_ff, work_in;
   mask_type          enable_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;

   logic              accept;
   logic [WIDE_W-1:0] req_idx_wide;
   logic [WIDE_W-1:0] walk_wide;
   logic              walk_enabled;
   logic [ADDR_W-1:0] cur_addr;
   logic [2:0]        after_roll;
   logic              rd_en;
   logic              wr_en;
   entry_type         rd_data;
   alu_req_type       alu_req;
   alu_out_type       alu_out;
   result_type        done_data;

   isc_alu u_alu (
      .req (alu_req),
      .rsp (alu_out)
   );

   isc_store #(
      .DEPTH  (NUM_COUNTERS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (cur_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (cur_addr),
      .wr_data (work_ff)
   );

   // handshake and address helpers
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign req_idx_wide   = {{ADDR_W{1'b0}}, req_chan.counter_index};
   assign walk_wide      = {4'd0, walk_ff};
   assign walk_enabled   = enable_ff[walk_wide[3:0]];
   assign cur_addr       = roll_ff ? walk_ff : idx_addr_ff;
   assign after_roll     = idx_ok_ff ? ST_READ : ST_DONE;

   // result beat from the working entry; out-of-bank index reports zeros
   always_comb begin
      done_data = '0;
      if (idx_ok_ff) begin
         done_data.total_calls       = work_ff.call_total;
         done_data.total_ticks       = work_ff.tick_total;
         done_data.longest_interval  = work_ff.max_interval;
         done_data.period_calls      = work_ff.calls_in_period;
         done_data.period_ticks      = work_ff.ticks_in_period;
         done_data.peak_period_calls = work_ff.max_period_calls;
         done_data.peak_period_ticks = work_ff.max_period_ticks;
         done_data.is_running        = work_ff.running;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      roll_in      = roll_ff;
      walk_in      = walk_ff;
      kind_in      = kind_ff;
      idx_addr_in  = idx_addr_ff;
      idx_ok_in    = idx_ok_ff;
      now_in       = now_ff;
      elapsed_in   = elapsed_ff;
      work_in      = work_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      alu_req      = '{mode: ALU_SUB, a: now_ff, b: work_ff.start_tick};
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in     = req_chan.kind;
               idx_addr_in = req_idx_wide[ADDR_W-1:0];
               idx_ok_in   = ({5'd0, req_chan.counter_index} < NUM_LIMIT);
               now_in      = req_chan.now_ticks;
               walk_in     = '0;
               work_in     = '0;
               if (req_chan.kind == KIND_PERIOD) begin
                  roll_in  = 1'b1;
                  state_in = ST_SCAN;
               end else if ({5'd0, req_chan.counter_index} < NUM_LIMIT) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (walk_enabled) begin
               rd_en    = 1'b1;
               state_in = ST_LOAD;
            end else if (walk_ff == ROLL_LAST) begin
               roll_in  = 1'b0;
               state_in = after_roll;
            end else begin
               walk_in = walk_ff + 1'b1;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            work_in = rd_data;
            if (roll_ff) begin
               op_in    = OP_PKCALLS;
               state_in = ST_EXEC;
            end else if (kind_ff == KIND_STOP && rd_data.running) begin
               op_in    = OP_ELAPSED;
               state_in = ST_EXEC;
            end else if (kind_ff == KIND_START && !rd_data.running) begin
               work_in.running    = 1'b1;
               work_in.start_tick = now_ff;
               state_in           = ST_WRITE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               OP_ELAPSED: begin
                  alu_req    = '{mode: ALU_SUB, a: now_ff, b: work_ff.start_tick};
                  elapsed_in = alu_out.result;
                  op_in      = OP_CALLS;
               end
               OP_CALLS: begin
                  alu_req            = '{mode: ALU_SATADD, a: work_ff.call_total, b: 32'd1};
                  work_in.call_total = alu_out.result;
                  op_in              = OP_TICKS;
               end
               OP_TICKS: begin
                  alu_req            = '{mode: ALU_SATADD, a: work_ff.tick_total,
                                         b: elapsed_ff};
                  work_in.tick_total = alu_out.result;
                  op_in              = OP_PCALLS;
               end
               OP_PCALLS: begin
                  alu_req                 = '{mode: ALU_SATADD, a: work_ff.calls_in_period,
                                              b: 32'd1};
                  work_in.calls_in_period = alu_out.result;
                  op_in                   = OP_PTICKS;
               end
               OP_PTICKS: begin
                  alu_req                 = '{mode: ALU_SATADD, a: work_ff.ticks_in_period,
                                              b: elapsed_ff};
                  work_in.ticks_in_period = alu_out.result;
                  op_in                   = OP_MAXINT;
               end
               OP_MAXINT: begin
                  alu_req = '{mode: ALU_CMP, a: elapsed_ff, b: work_ff.max_interval};
                  if (alu_out.a_gt_b) begin
                     work_in.max_interval = elapsed_ff;
                  end
                  work_in.running = 1'b0;
                  state_in        = ST_WRITE;
               end
               OP_PKCALLS: begin
                  alu_req = '{mode: ALU_CMP, a: work_ff.calls_in_period,
                              b: work_ff.max_period_calls};
                  if (alu_out.a_gt_b) begin
                     work_in.max_period_calls = work_ff.calls_in_period;
                  end
                  op_in = OP_PKTICKS;
               end
               OP_PKTICKS: begin
                  alu_req = '{mode: ALU_CMP, a: work_ff.ticks_in_period,
                              b: work_ff.max_period_ticks};
                  if (alu_out.a_gt_b) begin
                     work_in.max_period_ticks = work_ff.ticks_in_period;
                  end
                  work_in.calls_in_period = '0;
                  work_in.ticks_in_period = '0;
                  state_in                = ST_WRITE;
               end
               default: begin
                  state_in = ST_WRITE;
               end
            endcase
         end
         ST_WRITE: begin
            wr_en = 1'b1;
            if (!roll_ff) begin
               state_in = ST_DONE;
            end else if (walk_ff == ROLL_LAST) begin
               roll_in  = 1'b0;
               state_in = after_roll;
            end else begin
               walk_in  = walk_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = done_data;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_ELAPSED;
         roll_ff      <= 1'b0;
         walk_ff      <= '0;
         enable_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         roll_ff      <= roll_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      idx_addr_ff <= idx_addr_in;
      idx_ok_ff   <= idx_ok_in;
      now_ff      <= now_in;
      elapsed_ff  <= elapsed_in;
      work_ff     <= work_in;
      rsp_data_ff <= rsp_data_in;
   end

   // response channel
   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.total_calls       = rsp_data_ff.total_calls;
   assign rsp_chan.total_ticks       = rsp_data_ff.total_ticks;
   assign rsp_chan.longest_interval  = rsp_data_ff.longest_interval;
   assign rsp_chan.period_calls      = rsp_data_ff.period_calls;
   assign rsp_chan.period_ticks      = rsp_data_ff.period_ticks;
   assign rsp_chan.peak_period_calls = rsp_data_ff.peak_period_calls;
   assign rsp_chan.peak_period_ticks = rsp_data_ff.peak_period_ticks;
   assign rsp_chan.is_running        = rsp_data_ff.is_running;

   // an accepted beat always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("sequencer stayed idle after accepting a request beat");

   // a start on a bank counter leaves it running
   a_start_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && kind_ff == KIND_START && idx_ok_ff) |-> work_ff.running)
      else $error("start beat reported a counter that is not running");

   // a stop on a bank counter leaves it closed
   a_stop_closed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && kind_ff == KIND_STOP && idx_ok_ff) |-> !work_ff.running)
      else $error("stop beat reported a counter that is still running");

   // an out-of-bank index reports zeros
   a_bad_index_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !idx_ok_ff && (!rsp_valid_ff || rsp_chan.ready)) |=>
      (rsp_chan.valid && rsp_chan.total_calls == '0 && !rsp_chan.is_running))
      else $error("out-of-bank index produced nonzero statistics");

   // the store is only written from the write step, and a period walk writes back only enabled counters
   a_write_roll_addr: assert property (@(posedge clock) disable iff (reset)
      (wr_en && roll_ff) |-> walk_enabled)
      else $error("period walk wrote back a disabled counter");

endmodule

>>> hdl/isc_alu.sv
// shared 32-bit subtract, saturating add and compare unit
module isc_alu (
   input  isc_pkg::alu_req_type req,
   output isc_pkg::alu_out_type rsp
);
   import isc_pkg::*;

   word_type    x;
   word_type    y;
   logic        inv;
   logic [32:0] sum;

   // compare computes b - a, so a > b shows as a borrow
   always_comb begin
      x   = (req.mode == ALU_CMP) ? req.b : req.a;
      y   = (req.mode == ALU_CMP) ? req.a : req.b;
      inv = (req.mode != ALU_SATADD);
      sum = {1'b0, x} + {1'b0, (inv ? ~y : y)} + {32'd0, inv};
   end

   always_comb begin
      rsp.a_gt_b = 1'b0;
      unique case (req.mode)
         ALU_SUB: begin
            rsp.result = sum[31:0];
         end
         ALU_SATADD: begin
            rsp.result = sum[32] ? '1 : sum[31:0];
         end
         ALU_CMP: begin
            rsp.result = sum[31:0];
            rsp.a_gt_b = ~sum[32];
         end
         default: begin
            rsp.result = '0;
         end
      endcase
   end

endmodule

>>> hdl/isc_store.sv
// counter entry memory with per-entry valid bits for reset
module isc_store #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output isc_pkg::entry_type  rd_data,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  isc_pkg::entry_type  wr_data
);
   import isc_pkg::*;

   entry_type        mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   entry_type        rd_ff;
   logic             rd_valid_ff;

   // entry array, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // valid bits; an entry never written reads as all zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_ff : '0;

endmodule
